### sv/circular_queue_with_peek_assert.svh
// Assertion macros for the circular queue with peek.
// Used by the top level; depends on nothing else.
`ifndef CIRCULAR_QUEUE_WITH_PEEK_ASSERT_SVH
`define CIRCULAR_QUEUE_WITH_PEEK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CQP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CQP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cqp_pkg.sv
// Shared types and constants for the circular queue with peek.
// Used by the controller, the datapath and the top level; no dependencies.
package cqp_pkg;

  // Fixed field widths.
  localparam int CMD_W = 3;
  localparam int POS_W = 10;
  localparam int CAP_W = 10;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_EMPTY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FULL  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic do_read;
    logic load_direct;
    logic load_read;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_read;
    logic is_push;
  } dp_status_t;

endpackage

### sv/cqp_ctrl.sv
// Controller state machine for the circular queue with peek.
// Depends on cqp_pkg for the command and status structs.
module cqp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  cqp_pkg::dp_status_t st,
  output cqp_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  // The output register can take a new result when empty or being emptied.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Command decode from the current state and datapath status.
  always_comb begin
    cmd.load_in     = in_valid && in_ready;
    cmd.do_read     = (state == S_EXEC) && st.needs_read;
    cmd.load_direct = (state == S_EXEC) && !st.needs_read && out_free;
    cmd.load_read   = (state == S_LOAD) && out_free;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.load_in) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.do_read) state_next = S_LOAD;
        else if (cmd.load_direct) state_next = S_IDLE;
      end
      S_LOAD: begin
        if (cmd.load_read) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid is set by a load and cleared when the beat is taken.
  always_comb begin
    if (cmd.load_direct || cmd.load_read) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### sv/cqp_datapath.sv
// Datapath of the circular queue with peek: ring memory, pointers, count,
// input and output registers. Depends on cqp_pkg.
module cqp_datapath #(
  parameter int SLOT_COUNT = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        capacity_wr_en,
  input  logic [cqp_pkg::CAP_W-1:0]   capacity,
  input  logic [cqp_pkg::CMD_W-1:0]   command,
  input  logic signed [DATA_WIDTH-1:0] push_value,
  input  logic [cqp_pkg::POS_W-1:0]   position,
  output logic                        success,
  output logic signed [DATA_WIDTH-1:0] data,
  output logic                        answer,
  input  cqp_pkg::ctrl_cmd_t          cmd,
  output cqp_pkg::dp_status_t         st
);

  // The capacity field limits the ring to 2**CAP_W slots.
  localparam int RING_MAX = (SLOT_COUNT < (1 << cqp_pkg::CAP_W)) ?
                            SLOT_COUNT : (1 << cqp_pkg::CAP_W);
  localparam int PTR_W    = $clog2(RING_MAX);
  localparam int MOD_W    = PTR_W + 1;
  localparam int SUM_W    = cqp_pkg::POS_W + 1;

  logic [DATA_WIDTH-1:0]       mem [RING_MAX];
  logic [DATA_WIDTH-1:0]       rd_data;

  logic [cqp_pkg::CMD_W-1:0]   cmd_q;
  logic [DATA_WIDTH-1:0]       val_q;
  logic [cqp_pkg::POS_W-1:0]   pos_q;

  logic [MOD_W-1:0]            modulus;
  logic [MOD_W-1:0]            modulus_next;
  logic [PTR_W-1:0]            head;
  logic [PTR_W-1:0]            tail;
  logic [PTR_W-1:0]            count;
  logic [PTR_W-1:0]            last;

  logic [cqp_pkg::CAP_W:0]     cap_plus;
  logic [SUM_W-1:0]            qsum;
  logic [PTR_W-1:0]            q_addr;
  logic [PTR_W-1:0]            rd_addr;
  logic                        empty;
  logic                        full;
  logic                        query_ok;
  logic                        push_ok;

  // Ring modulus from a capacity write: capacity plus one, saturated.
  assign cap_plus     = (cqp_pkg::CAP_W + 1)'(capacity) + (cqp_pkg::CAP_W + 1)'(1);
  assign modulus_next = (cap_plus > (cqp_pkg::CAP_W + 1)'(RING_MAX)) ?
                        MOD_W'(RING_MAX) : MOD_W'(cap_plus);

  // Queue flags from the entry count.
  assign last     = PTR_W'(modulus - MOD_W'(1));
  assign empty    = (count == '0);
  assign full     = (count == last);
  assign query_ok = (pos_q != '0) && (pos_q <= cqp_pkg::POS_W'(count));
  assign push_ok  = (cmd_q == cqp_pkg::CMD_PUSH) && !full;

  // Query address: head plus position minus one, wrapped once.
  assign qsum   = SUM_W'(head) + SUM_W'(pos_q) - SUM_W'(1);
  assign q_addr = (qsum >= SUM_W'(modulus)) ? PTR_W'(qsum - SUM_W'(modulus))
                                            : PTR_W'(qsum);
  assign rd_addr = (cmd_q == cqp_pkg::CMD_POP) ? head : q_addr;

  // Status to the controller.
  always_comb begin
    st.needs_read = ((cmd_q == cqp_pkg::CMD_POP) && !empty) ||
                    ((cmd_q == cqp_pkg::CMD_QUERY) && query_ok);
    st.is_push    = (cmd_q == cqp_pkg::CMD_PUSH);
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_q <= command;
      val_q <= push_value;
      pos_q <= position;
    end
  end

  // Ring memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load_direct && push_ok) mem[tail] <= val_q;
    if (cmd.do_read) rd_data <= mem[rd_addr];
  end

  // Pointers, count and modulus.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_W'(RING_MAX);
      head    <= '0;
      tail    <= '0;
      count   <= '0;
    end else if (capacity_wr_en) begin
      modulus <= modulus_next;
      head    <= '0;
      tail    <= '0;
      count   <= '0;
    end else if (cmd.load_direct && push_ok) begin
      tail  <= (tail == last) ? '0 : tail + PTR_W'(1);
      count <= count + PTR_W'(1);
    end else if (cmd.do_read && (cmd_q == cqp_pkg::CMD_POP)) begin
      head  <= (head == last) ? '0 : head + PTR_W'(1);
      count <= count - PTR_W'(1);
    end
  end

  // Output register, loaded only when the controller sees it free.
  always_ff @(posedge clk) begin
    if (cmd.load_read) begin
      success <= 1'b1;
      data    <= rd_data;
      answer  <= 1'b0;
    end else if (cmd.load_direct) begin
      success <= 1'b0;
      data    <= '0;
      answer  <= 1'b0;
      case (cmd_q)
        cqp_pkg::CMD_PUSH:  success <= !full;
        cqp_pkg::CMD_EMPTY: answer  <= empty;
        cqp_pkg::CMD_FULL:  answer  <= full;
        default:            answer  <= 1'b0;
      endcase
    end
  end

endmodule

### sv/circular_queue_with_peek.sv
// Top level of the circular queue with peek: controller plus datapath.
// Depends on cqp_pkg, cqp_ctrl, cqp_datapath and the assertion header.
//
// Usage: commands arrive on the input channel (in_valid/in_ready) with
// command, push_value and position; each gives exactly one result beat on
// the output channel (out_valid/out_ready) with success, data and answer.
// The queue holds at most capacity entries, set through capacity_wr_en and
// capacity; a write empties the queue. The user must make the write only
// while the block is idle; the block does not enforce this. One command is
// in work at a time, and the next is taken once the last result is loaded.
// Push, is_empty, is_full, failed pops and failed queries load their result
// straight from the input register; a successful pop or query first reads
// the ring through its registered read port. The output register holds a
// finished result while the receiver stalls; the next command is accepted
// meanwhile and waits in the datapath until the output register is free.
// Reset empties the queue and sets capacity to 1023 (the ring saturates at
// the lesser of 2**CAP_W and SLOT_COUNT slots). No clearing pass is needed.
`include "circular_queue_with_peek_assert.svh"

module circular_queue_with_peek #(
  parameter int SLOT_COUNT = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         capacity_wr_en,
  input  logic [cqp_pkg::CAP_W-1:0]    capacity,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cqp_pkg::CMD_W-1:0]    command,
  input  logic signed [DATA_WIDTH-1:0] push_value,
  input  logic [cqp_pkg::POS_W-1:0]    position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         success,
  output logic signed [DATA_WIDTH-1:0] data,
  output logic                         answer
);

  cqp_pkg::ctrl_cmd_t  cmd;
  cqp_pkg::dp_status_t st;

  // Control sequencing.
  cqp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  cqp_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .capacity_wr_en (capacity_wr_en),
    .capacity       (capacity),
    .command        (command),
    .push_value     (push_value),
    .position       (position),
    .success        (success),
    .data           (data),
    .answer         (answer),
    .cmd            (cmd),
    .st             (st)
  );

  // A result is loaded only when the output register is free.
  `CQP_ASSERT_NOW(a_load_when_free, clk, rst, cmd.load_direct || cmd.load_read, !out_valid || out_ready, "result loaded over a pending beat")
  // Only one command is in work at a time.
  `CQP_ASSERT_NEXT(a_one_in_work, clk, rst, cmd.load_in, !in_ready, "command accepted while another is in work")
  // A memory read never coincides with a push.
  `CQP_ASSERT_NOW(a_read_not_push, clk, rst, cmd.do_read, !st.is_push, "memory read issued for a push")

endmodule

### tb/circular_queue_with_peek_test.sv
// Self-checking testbench for circular_queue_with_peek: directed and random commands.
// Depends on cqp_pkg and the circular_queue_with_peek RTL. It reads no files.
module circular_queue_with_peek_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 1024;
  localparam int DATA_W = 32;
  localparam int CMD_W = cqp_pkg::CMD_W;
  localparam int POS_W = cqp_pkg::POS_W;
  localparam int CAP_W = cqp_pkg::CAP_W;
  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NUM_PHASES = 10;
  localparam int FILL_PHASE = 2;
  localparam int PHASE_ITEMS = 70;
  localparam logic [CMD_W-1:0] CMD_TOP = {CMD_W{1'b1}};
  localparam logic [POS_W-1:0] POS_TOP = {POS_W{1'b1}};
  localparam logic [CAP_W-1:0] CAP_TOP = {CAP_W{1'b1}};

  // One result beat as seen on the output channel.
  typedef struct packed {
    logic                     success;
    logic signed [DATA_W-1:0] data;
    logic                     answer;
  } queue_result_t;

  // Ring predictor plus the store of results still owed by the block.
  class queue_scoreboard;
    logic signed [DATA_W-1:0] ring [SLOTS];
    int unsigned head_ptr;
    int unsigned tail_ptr;
    logic [CAP_W-1:0] cap;
    queue_result_t owed_q[$];
    int errors;
    int commands;
    int full_refusals;
    int peek_hits;

    function new();
      cap = CAP_TOP;
      head_ptr = 0;
      tail_ptr = 0;
      errors = 0;
      commands = 0;
      full_refusals = 0;
      peek_hits = 0;
    endfunction

    // Ring modulus: capacity plus one, saturating at the slot count.
    function int unsigned ring_len();
      int unsigned m;
      m = int'(cap) + 1;
      if (m > SLOTS) m = SLOTS;
      return m;
    endfunction

    function int unsigned occupancy();
      int unsigned m;
      m = ring_len();
      return ((tail_ptr % m) + m - (head_ptr % m)) % m;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // A capacity write also empties the queue.
    function void set_capacity(logic [CAP_W-1:0] value);
      cap = value;
      head_ptr = 0;
      tail_ptr = 0;
    endfunction

    // Applies an accepted command to the predicted ring and notes its result.
    function void note_command(logic [CMD_W-1:0] cmd,
                               logic signed [DATA_W-1:0] value,
                               logic [POS_W-1:0] pos);
      int unsigned m;
      int unsigned nxt;
      int unsigned cnt;
      queue_result_t r;
      m = ring_len();
      head_ptr = head_ptr % m;
      tail_ptr = tail_ptr % m;
      nxt = (tail_ptr + 1) % m;
      cnt = (tail_ptr + m - head_ptr) % m;
      r = '0;
      commands++;
      case (cmd)
        cqp_pkg::CMD_PUSH: begin
          if (head_ptr != nxt) begin
            ring[tail_ptr] = value;
            tail_ptr = nxt;
            r.success = 1'b1;
          end else begin
            full_refusals++;
          end
        end
        cqp_pkg::CMD_POP: begin
          if (head_ptr != tail_ptr) begin
            r.success = 1'b1;
            r.data = ring[head_ptr];
            head_ptr = (head_ptr + 1) % m;
          end
        end
        cqp_pkg::CMD_QUERY: begin
          if (pos != 0 && pos <= cnt) begin
            r.success = 1'b1;
            r.data = ring[(head_ptr + pos - 1) % m];
            peek_hits++;
          end
        end
        cqp_pkg::CMD_EMPTY: r.answer = (head_ptr == tail_ptr);
        cqp_pkg::CMD_FULL: r.answer = (head_ptr == nxt);
        default: ;
      endcase
      owed_q.push_back(r);
    endfunction

    // Compares one result beat with the oldest owed result.
    function void check_result(logic s, logic signed [DATA_W-1:0] d, logic a);
      queue_result_t e;
      if (owed_q.size() == 0) begin
        $error("result beat with nothing owed: success=%0b data=%0d answer=%0b", s, d, a);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (s !== e.success) begin
        $error("success mismatch: expected %0b, actual %0b", e.success, s);
        errors++;
      end
      if (d !== e.data) begin
        $error("data mismatch: expected %0d, actual %0d", e.data, d);
        errors++;
      end
      if (a !== e.answer) begin
        $error("answer mismatch: expected %0b, actual %0b", e.answer, a);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     capacity_wr_en = 1'b0;
  logic [CAP_W-1:0]         capacity = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         command = '0;
  logic signed [DATA_W-1:0] push_value = '0;
  logic [POS_W-1:0]         position = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     success;
  logic signed [DATA_W-1:0] data;
  logic                     answer;

  queue_scoreboard sb;
  logic quiet = 1'b0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int   ready_gap = 0;
  int   idle_cycles = 0;
  int   settings_used = 0;

  circular_queue_with_peek #(
    .SLOT_COUNT(SLOTS),
    .DATA_WIDTH(DATA_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .capacity_wr_en(capacity_wr_en),
    .capacity(capacity),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .push_value(push_value),
    .position(position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .success(success),
    .data(data),
    .answer(answer)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver: checks each result beat and stalls in random bursts, plus one long stall on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_gap <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_result(success, data, answer);
      if (long_hold_req && !long_hold_done) begin
        out_ready <= 1'b0;
        ready_gap <= LONG_HOLD;
        long_hold_done <= 1'b1;
      end else if (ready_gap > 1) begin
        out_ready <= 1'b0;
        ready_gap <= ready_gap - 1;
      end else if (ready_gap == 1) begin
        out_ready <= 1'b1;
        ready_gap <= 0;
      end else if (!quiet && $urandom_range(0, 99) < 10) begin
        out_ready <= 1'b0;
        ready_gap <= $urandom_range(1, 12);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one command beat, maybe after a random gap, and waits for acceptance.
  task automatic send_command(input logic [CMD_W-1:0] cmd,
                              input logic signed [DATA_W-1:0] value,
                              input logic [POS_W-1:0] pos);
    int gap;
    if (!quiet && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    push_value <= value;
    position <= pos;
    do @(posedge clk); while (!in_ready);
    sb.note_command(cmd, value, pos);
  endtask

  // Draws a random command; push and pop weights are in percent.
  task automatic send_random(input int push_w, input int pop_w);
    int r;
    int rest;
    int x;
    int unsigned cnt;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    rest = 100 - push_w - pop_w;
    x = (r - push_w - pop_w) * 100;
    cnt = sb.occupancy();
    pos = POS_W'($urandom_range(0, int'(POS_TOP)));
    if (r < push_w) cmd = cqp_pkg::CMD_PUSH;
    else if (r < push_w + pop_w) cmd = cqp_pkg::CMD_POP;
    else if (x < rest * 60) cmd = cqp_pkg::CMD_QUERY;
    else if (x < rest * 78) cmd = cqp_pkg::CMD_EMPTY;
    else if (x < rest * 96) cmd = cqp_pkg::CMD_FULL;
    else cmd = CMD_W'($urandom_range(int'(cqp_pkg::CMD_FULL) + 1, int'(CMD_TOP)));
    // Queries mostly hit a live entry, sometimes just past the end or zero.
    if (cmd == cqp_pkg::CMD_QUERY) begin
      x = $urandom_range(0, 99);
      if (x < 75) pos = POS_W'($urandom_range(1, (cnt > 0) ? cnt : 1));
      else if (x < 85) pos = (cnt < POS_TOP) ? POS_W'(cnt + 1) : POS_TOP;
      else if (x < 90) pos = '0;
    end
    send_command(cmd, $urandom(), pos);
  endtask

  // Lowers valid and waits until every owed result has been taken.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    capacity_wr_en <= 1'b1;
    capacity <= value;
    @(posedge clk);
    capacity_wr_en <= 1'b0;
    sb.set_capacity(value);
    settings_used++;
  endtask

  function automatic logic [CAP_W-1:0] capacity_for_phase(input int p);
    case (p)
      0: return 10'd2;
      1: return 10'd7;
      2: return CAP_TOP;
      3: return 10'd1;
      4: return 10'd16;
      5: return '0;
      6: return 10'd3;
      7: return 10'd64;
      8: return CAP_TOP;
      default: return 10'd5;
    endcase
  endfunction

  // Main sequence: reset, directed checks, then random phases per capacity.
  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty queue at reset capacity, extreme values, bad positions, unknown codes.
    send_command(cqp_pkg::CMD_EMPTY, '0, '0);
    send_command(cqp_pkg::CMD_FULL, '0, '0);
    send_command(cqp_pkg::CMD_POP, '0, '0);
    send_command(cqp_pkg::CMD_QUERY, '0, 10'd1);
    send_command(cqp_pkg::CMD_PUSH, 32'sh8000_0000, '0);
    send_command(cqp_pkg::CMD_PUSH, 32'sh7FFF_FFFF, POS_TOP);
    send_command(cqp_pkg::CMD_PUSH, '0, '0);
    send_command(cqp_pkg::CMD_PUSH, -32'sd1, POS_TOP);
    send_command(cqp_pkg::CMD_QUERY, -32'sd1, '0);
    send_command(cqp_pkg::CMD_QUERY, '0, 10'd4);
    send_command(cqp_pkg::CMD_QUERY, '0, 10'd5);
    send_command(cqp_pkg::CMD_QUERY, '0, POS_TOP);
    send_command(cqp_pkg::CMD_POP, '0, '0);
    for (int c = int'(cqp_pkg::CMD_FULL) + 1; c <= int'(CMD_TOP); c++)
      send_command(CMD_W'(c), $urandom(), POS_W'($urandom_range(0, int'(POS_TOP))));
    send_command(cqp_pkg::CMD_EMPTY, '0, '0);

    // Capacity zero: the queue is both empty and full, and everything fails.
    wait_idle();
    write_capacity('0);
    send_command(cqp_pkg::CMD_EMPTY, '0, '0);
    send_command(cqp_pkg::CMD_FULL, '0, '0);
    send_command(cqp_pkg::CMD_PUSH, 32'sd42, '0);
    send_command(cqp_pkg::CMD_POP, '0, '0);
    send_command(cqp_pkg::CMD_QUERY, '0, 10'd1);

    // Capacity one: a single entry fills the ring.
    wait_idle();
    write_capacity(10'd1);
    send_command(cqp_pkg::CMD_PUSH, 32'sd1234, '0);
    send_command(cqp_pkg::CMD_PUSH, 32'sd5678, '0);
    send_command(cqp_pkg::CMD_FULL, '0, '0);
    send_command(cqp_pkg::CMD_QUERY, '0, 10'd1);
    send_command(cqp_pkg::CMD_POP, '0, '0);

    // Random phases; the fill phase runs the full ring against a long stall.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_capacity(capacity_for_phase(p));
      if (p == NUM_PHASES - 1) quiet <= 1'b1;
      if (p == FILL_PHASE) begin
        long_hold_req <= 1'b1;
        while (sb.occupancy() < int'(capacity_for_phase(p))) send_random(93, 0);
        repeat (30) send_random(40, 30);
      end else begin
        repeat (PHASE_ITEMS) send_random(45, 35);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d commands across %0d capacity settings, zero up to a full ring.",
             sb.commands, settings_used);
    $display("Saw %0d refused pushes, %0d good peeks, one %0d-cycle receiver stall.",
             sb.full_refusals, sb.peek_hits, LONG_HOLD);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
